@@ design/bs2d_pkg.sv @@
// ---------------------------------------------------------------------------
// bs2d_pkg
// Shared types and constants of the two-dimensional box smoothing engine.
// ---------------------------------------------------------------------------
package bs2d_pkg;

	localparam int MAX_ROWS = 256;
	localparam int MAX_COLS = 256;
	localparam int MAX_HALF = 8;

	localparam int ROW_W    = 8;
	localparam int COL_W    = 8;
	localparam int SAMPLE_W = 16;
	localparam int HALF_W   = 4;
	localparam int DIM_W    = 9;
	localparam int CFG_W    = 9;

	localparam int STORE_ROW_W = $clog2(MAX_ROWS);
	localparam int STORE_COL_W = $clog2(MAX_COLS);
	localparam int ADDR_W      = STORE_ROW_W + STORE_COL_W;
	localparam int DEPTH       = MAX_ROWS * MAX_COLS;

	localparam int ROWS_LIMIT = (MAX_ROWS < 256) ? MAX_ROWS : 256;
	localparam int COLS_LIMIT = (MAX_COLS < 256) ? MAX_COLS : 256;

	// Window walk counters and signed window coordinates.
	localparam int SPAN_W  = $clog2(2 * MAX_HALF);
	localparam int COORD_W = DIM_W + 1;

	// Window sum and divisor widths.
	localparam int AREA_MAX = 4 * MAX_HALF * MAX_HALF;
	localparam int SUM_W    = SAMPLE_W + $clog2(AREA_MAX);
	localparam int DIV_W    = $clog2(AREA_MAX + 1);
	localparam int STEP_W   = $clog2(SUM_W);

	localparam logic [HALF_W-1:0] HALF_W_RESET = HALF_W'(1);
	localparam logic [HALF_W-1:0] HALF_H_RESET = HALF_W'(1);
	localparam logic [DIM_W-1:0]  COLS_RESET   = DIM_W'(256);
	localparam logic [DIM_W-1:0]  ROWS_RESET   = DIM_W'(256);

	typedef enum logic [1:0] {
		CFG_HALF_COLS = 2'd0,
		CFG_HALF_ROWS = 2'd1,
		CFG_IMG_COLS  = 2'd2,
		CFG_IMG_ROWS  = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		FUNC_LOAD   = 1'b0,
		FUNC_SMOOTH = 1'b1
	} func_t;

	// Effective (clamped) window and image geometry.
	typedef struct packed {
		logic [HALF_W-1:0] half_w;
		logic [HALF_W-1:0] half_h;
		logic [DIM_W-1:0]  cols;
		logic [DIM_W-1:0]  rows;
	} win_cfg_t;

	function automatic logic [HALF_W-1:0] clamp_half(input logic [HALF_W-1:0] v);
		logic [HALF_W-1:0] r;
		r = v;
		if (v == '0)
			r = HALF_W'(1);
		else if (int'(v) > MAX_HALF)
			r = HALF_W'(MAX_HALF);
		return r;
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] lim);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > lim)
			r = lim;
		return r;
	endfunction

endpackage

@@ design/bs2d_ram.sv @@
// ---------------------------------------------------------------------------
// bs2d_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ---------------------------------------------------------------------------
module bs2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

@@ design/bs2d_win.sv @@
// ---------------------------------------------------------------------------
// bs2d_win
// Window walker: reads the 2H x 2W window one sample per cycle from the
// image store and accumulates the samples that lie inside the image.
// ---------------------------------------------------------------------------
module bs2d_win (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [bs2d_pkg::ROW_W-1:0]         row,
	input  logic [bs2d_pkg::COL_W-1:0]         col,
	input  bs2d_pkg::win_cfg_t                 cfg,
	output logic                               rd_en,
	output logic [bs2d_pkg::ADDR_W-1:0]        rd_addr,
	input  logic [bs2d_pkg::SAMPLE_W-1:0]      rd_data,
	output logic                               done,
	output logic signed [bs2d_pkg::SUM_W-1:0]  sum
);

	logic                              busy_q;
	logic [bs2d_pkg::SPAN_W-1:0]       ri_q;
	logic [bs2d_pkg::SPAN_W-1:0]       ci_q;
	logic [bs2d_pkg::ROW_W-1:0]        row_q;
	logic [bs2d_pkg::COL_W-1:0]        col_q;
	bs2d_pkg::win_cfg_t                cfg_q;
	logic                              vld_s1;
	logic                              inr_s1;
	logic                              last_s1;
	logic                              done_s2;
	logic signed [bs2d_pkg::SUM_W-1:0] acc_q;

	logic signed [bs2d_pkg::COORD_W-1:0] r_pos;
	logic signed [bs2d_pkg::COORD_W-1:0] c_pos;
	logic [bs2d_pkg::SPAN_W-1:0]         ri_last;
	logic [bs2d_pkg::SPAN_W-1:0]         ci_last;
	logic                                row_in;
	logic                                col_in;
	logic                                col_end;
	logic                                last;

	always_comb begin
		r_pos = $signed(bs2d_pkg::COORD_W'(row_q)) - $signed(bs2d_pkg::COORD_W'(cfg_q.half_h))
			+ $signed(bs2d_pkg::COORD_W'(ri_q));
		c_pos = $signed(bs2d_pkg::COORD_W'(col_q)) - $signed(bs2d_pkg::COORD_W'(cfg_q.half_w))
			+ $signed(bs2d_pkg::COORD_W'(ci_q));
		ri_last = bs2d_pkg::SPAN_W'({cfg_q.half_h, 1'b0} - 1'b1);
		ci_last = bs2d_pkg::SPAN_W'({cfg_q.half_w, 1'b0} - 1'b1);
		row_in  = !r_pos[bs2d_pkg::COORD_W-1] && (r_pos[bs2d_pkg::DIM_W-1:0] < cfg_q.rows);
		col_in  = !c_pos[bs2d_pkg::COORD_W-1] && (c_pos[bs2d_pkg::DIM_W-1:0] < cfg_q.cols);
		col_end = (ci_q == ci_last);
		last    = col_end && (ri_q == ri_last);
	end

	// Out-of-image positions still issue a read; their data is dropped.
	assign rd_en   = busy_q;
	assign rd_addr = {r_pos[bs2d_pkg::STORE_ROW_W-1:0], c_pos[bs2d_pkg::STORE_COL_W-1:0]};
	assign done    = done_s2;
	assign sum     = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			ri_q    <= '0;
			ci_q    <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			vld_s1  <= busy_q;
			last_s1 <= busy_q && last;
			done_s2 <= vld_s1 && last_s1;
			if (start) begin
				busy_q <= 1'b1;
				ri_q   <= '0;
				ci_q   <= '0;
			end else if (busy_q) begin
				if (last)
					busy_q <= 1'b0;
				if (col_end) begin
					ci_q <= '0;
					ri_q <= ri_q + 1'b1;
				end else begin
					ci_q <= ci_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		inr_s1 <= row_in && col_in;
		if (start) begin
			row_q <= row;
			col_q <= col;
			cfg_q <= cfg;
			acc_q <= '0;
		end else if (vld_s1 && inr_s1) begin
			acc_q <= acc_q + bs2d_pkg::SUM_W'($signed(rd_data));
		end
	end

endmodule

@@ design/bs2d_div.sv @@
// ---------------------------------------------------------------------------
// bs2d_div
// Radix-2 restoring divider: signed window sum over the unsigned window
// area, one quotient bit per cycle, truncating toward zero.
// ---------------------------------------------------------------------------
module bs2d_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [bs2d_pkg::SUM_W-1:0]    dividend,
	input  logic [bs2d_pkg::DIV_W-1:0]           divisor,
	output logic                                 done,
	output logic signed [bs2d_pkg::SAMPLE_W-1:0] quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [bs2d_pkg::STEP_W-1:0]   cnt_q;
	logic                          neg_q;
	logic [bs2d_pkg::SUM_W-1:0]    quo_q;
	logic [bs2d_pkg::DIV_W-1:0]    rem_q;
	logic [bs2d_pkg::DIV_W-1:0]    div_q;

	logic [bs2d_pkg::DIV_W:0]      rem_sh;
	logic [bs2d_pkg::DIV_W:0]      rem_nx;
	logic                          ge;
	logic [bs2d_pkg::SAMPLE_W-1:0] mag;
	logic                          cnt_end;

	always_comb begin
		rem_sh  = {rem_q, quo_q[bs2d_pkg::SUM_W-1]};
		ge      = (rem_sh >= {1'b0, div_q});
		rem_nx  = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
		mag     = quo_q[bs2d_pkg::SAMPLE_W-1:0];
		cnt_end = (cnt_q == bs2d_pkg::STEP_W'(bs2d_pkg::SUM_W - 1));
	end

	assign done     = done_q;
	assign quotient = neg_q ? $signed(-mag) : $signed(mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && cnt_end;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_end)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[bs2d_pkg::SUM_W-1];
			quo_q <= dividend[bs2d_pkg::SUM_W-1] ? -dividend : dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[bs2d_pkg::SUM_W-2:0], ge};
			rem_q <= rem_nx[bs2d_pkg::DIV_W-1:0];
		end
	end

endmodule

@@ design/box_smooth_2d_top.sv @@
// Flow: a load is written to the store as it is accepted; a smooth item walks the
// 2W x 2H window through the store reads and the read pipeline, then the divider, then the
// quotient register and the hand-off to the output register.
// Throughput: one item at a time, as the input stalls outside ST_IDLE and the store has a
// single read port; the next item can be accepted in the same cycle that the result shows.
// Reset sets W = H = 1 and a 256 x 256 image and clears control state, not the store.
// ---------------------------------------------------------------------------
// box_smooth_2d_top
// Zero-padded two-dimensional box smoothing engine over an image store.
// ---------------------------------------------------------------------------
module box_smooth_2d_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  bs2d_pkg::cfg_idx_t                   cfg_index,
	input  logic [bs2d_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 func,
	input  logic [bs2d_pkg::ROW_W-1:0]           row,
	input  logic [bs2d_pkg::COL_W-1:0]           col,
	input  logic signed [bs2d_pkg::SAMPLE_W-1:0] sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [bs2d_pkg::ROW_W-1:0]           out_row,
	output logic [bs2d_pkg::COL_W-1:0]           out_col,
	output logic signed [bs2d_pkg::SAMPLE_W-1:0] smoothed
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WIN,
		ST_DIV,
		ST_PUT
	} state_t;

	state_t                                state_q;
	logic [bs2d_pkg::HALF_W-1:0]           half_w_q;
	logic [bs2d_pkg::HALF_W-1:0]           half_h_q;
	logic [bs2d_pkg::DIM_W-1:0]            cols_q;
	logic [bs2d_pkg::DIM_W-1:0]            rows_q;
	logic [bs2d_pkg::ROW_W-1:0]            row_q;
	logic [bs2d_pkg::COL_W-1:0]            col_q;
	logic signed [bs2d_pkg::SAMPLE_W-1:0]  res_q;
	logic                                  out_valid_q;
	logic [bs2d_pkg::ROW_W-1:0]            out_row_q;
	logic [bs2d_pkg::COL_W-1:0]            out_col_q;
	logic signed [bs2d_pkg::SAMPLE_W-1:0]  out_data_q;

	bs2d_pkg::win_cfg_t                    win_cfg;
	logic [2*bs2d_pkg::HALF_W-1:0]         area;
	logic [bs2d_pkg::DIV_W-1:0]            divisor;
	logic                                  in_xfer;
	logic                                  wr_en;
	logic                                  in_store;
	logic                                  win_start;
	logic                                  rd_en;
	logic [bs2d_pkg::ADDR_W-1:0]           rd_addr;
	logic [bs2d_pkg::SAMPLE_W-1:0]         rd_data;
	logic                                  win_done;
	logic signed [bs2d_pkg::SUM_W-1:0]     win_sum;
	logic                                  div_done;
	logic signed [bs2d_pkg::SAMPLE_W-1:0]  quotient;
	logic                                  out_free;

	always_comb begin
		win_cfg.half_w = bs2d_pkg::clamp_half(half_w_q);
		win_cfg.half_h = bs2d_pkg::clamp_half(half_h_q);
		win_cfg.cols   = bs2d_pkg::clamp_dim(cols_q, bs2d_pkg::DIM_W'(bs2d_pkg::COLS_LIMIT));
		win_cfg.rows   = bs2d_pkg::clamp_dim(rows_q, bs2d_pkg::DIM_W'(bs2d_pkg::ROWS_LIMIT));
		area     = win_cfg.half_w * win_cfg.half_h;
		divisor  = bs2d_pkg::DIV_W'({area, 2'b00});
		in_store = (int'(row) < bs2d_pkg::MAX_ROWS) && (int'(col) < bs2d_pkg::MAX_COLS);
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign wr_en     = in_xfer && (func == bs2d_pkg::FUNC_LOAD) && in_store;
	assign win_start = in_xfer && (func == bs2d_pkg::FUNC_SMOOTH);
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign smoothed  = out_data_q;

	bs2d_ram #(
		.WIDTH (bs2d_pkg::SAMPLE_W),
		.DEPTH (bs2d_pkg::DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr ({row[bs2d_pkg::STORE_ROW_W-1:0], col[bs2d_pkg::STORE_COL_W-1:0]}),
		.wr_data (sample),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bs2d_win u_win (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (win_start),
		.row     (row),
		.col     (col),
		.cfg     (win_cfg),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.done    (win_done),
		.sum     (win_sum)
	);

	bs2d_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (win_done),
		.dividend (win_sum),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_w_q <= bs2d_pkg::HALF_W_RESET;
			half_h_q <= bs2d_pkg::HALF_H_RESET;
			cols_q   <= bs2d_pkg::COLS_RESET;
			rows_q   <= bs2d_pkg::ROWS_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				bs2d_pkg::CFG_HALF_COLS: half_w_q <= cfg_data[bs2d_pkg::HALF_W-1:0];
				bs2d_pkg::CFG_HALF_ROWS: half_h_q <= cfg_data[bs2d_pkg::HALF_W-1:0];
				bs2d_pkg::CFG_IMG_COLS:  cols_q   <= cfg_data[bs2d_pkg::DIM_W-1:0];
				bs2d_pkg::CFG_IMG_ROWS:  rows_q   <= cfg_data[bs2d_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and output register. A finished result waits in ST_PUT until
	// the output register is free or its current transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			out_data_q  <= '0;
		end else begin
			if (state_q == ST_PUT && out_free) begin
				out_valid_q <= 1'b1;
				out_row_q   <= row_q;
				out_col_q   <= col_q;
				out_data_q  <= res_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (win_start)
						state_q <= ST_WIN;
				end
				ST_WIN: begin
					if (win_done)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_PUT;
				end
				ST_PUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (win_start) begin
			row_q <= row;
			col_q <= col;
		end
		if (div_done)
			res_q <= quotient;
	end

	a_store_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == ST_IDLE)
		else $error("store write outside idle state");

	a_win_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		win_done |-> state_q == ST_WIN)
		else $error("window sum finished outside window state");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside divide state");

	a_out_from_put: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_PUT)
		else $error("result presented without a finished smooth item");

endmodule

@@ bench/box_smooth_2d_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// box_smooth_2d_checker
// Watches the register port and both channels of the box smoothing engine.
// Keeps a private copy of the image store and window geometry, predicts the
// average for every smooth transfer and compares each output transfer with
// the oldest prediction.
// ---------------------------------------------------------------------------
module box_smooth_2d_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  bs2d_pkg::cfg_idx_t                   cfg_index,
	input  logic [bs2d_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic                                 func,
	input  logic [bs2d_pkg::ROW_W-1:0]           row,
	input  logic [bs2d_pkg::COL_W-1:0]           col,
	input  logic signed [bs2d_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic [bs2d_pkg::ROW_W-1:0]           out_row,
	input  logic [bs2d_pkg::COL_W-1:0]           out_col,
	input  logic signed [bs2d_pkg::SAMPLE_W-1:0] smoothed,
	output int                                   averages_owed,
	output int                                   mismatch_count
);

	typedef struct packed {
		logic [bs2d_pkg::ROW_W-1:0]           r;
		logic [bs2d_pkg::COL_W-1:0]           c;
		logic signed [bs2d_pkg::SAMPLE_W-1:0] avg;
	} average_t;

	logic signed [bs2d_pkg::SAMPLE_W-1:0] image_copy [0:bs2d_pkg::DEPTH-1];
	logic [bs2d_pkg::HALF_W-1:0]          half_cols;
	logic [bs2d_pkg::HALF_W-1:0]          half_rows;
	logic [bs2d_pkg::DIM_W-1:0]           used_cols;
	logic [bs2d_pkg::DIM_W-1:0]           used_rows;
	average_t                             pending_averages [$];

	function automatic int clip_to(input int v, input int lo, input int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Zero-padded window sum over the image in use, divided by the window area.
	function automatic logic signed [bs2d_pkg::SAMPLE_W-1:0] window_average(input int r,
		input int c);
		int     w, h, nr, nc, rr, cc;
		longint acc;
		w = clip_to(int'(half_cols), 1, bs2d_pkg::MAX_HALF);
		h = clip_to(int'(half_rows), 1, bs2d_pkg::MAX_HALF);
		nc = clip_to(int'(used_cols), 1, bs2d_pkg::COLS_LIMIT);
		nr = clip_to(int'(used_rows), 1, bs2d_pkg::ROWS_LIMIT);
		acc = 0;
		for (rr = r - h; rr < r + h; rr++)
			if (rr >= 0 && rr < nr)
				for (cc = c - w; cc < c + w; cc++)
					if (cc >= 0 && cc < nc)
						acc += image_copy[rr * bs2d_pkg::MAX_COLS + cc];
		return bs2d_pkg::SAMPLE_W'(acc / (4 * w * h));
	endfunction

	task automatic report(input string what, input logic signed [31:0] expected,
		input logic signed [31:0] actual);
		mismatch_count++;
		$display("%0t: %s expected %0d actual %0d", $time, what, expected, actual);
	endtask

	always @(posedge clk or negedge arst_n) begin
		average_t oldest;
		if (!arst_n) begin
			half_cols <= bs2d_pkg::HALF_W_RESET;
			half_rows <= bs2d_pkg::HALF_H_RESET;
			used_cols <= bs2d_pkg::COLS_RESET;
			used_rows <= bs2d_pkg::ROWS_RESET;
			pending_averages.delete();
			averages_owed <= 0;
		end else begin
			if (cfg_wr_en === 1'b1) begin
				case (cfg_index)
					bs2d_pkg::CFG_HALF_COLS:
						half_cols <= cfg_data[bs2d_pkg::HALF_W-1:0];
					bs2d_pkg::CFG_HALF_ROWS:
						half_rows <= cfg_data[bs2d_pkg::HALF_W-1:0];
					bs2d_pkg::CFG_IMG_COLS:
						used_cols <= cfg_data[bs2d_pkg::DIM_W-1:0];
					bs2d_pkg::CFG_IMG_ROWS:
						used_rows <= cfg_data[bs2d_pkg::DIM_W-1:0];
					default: ;
				endcase
			end
			if (in_valid === 1'b1 && in_stall === 1'b0) begin
				if (func == bs2d_pkg::FUNC_LOAD) begin
					if (int'(row) < bs2d_pkg::MAX_ROWS && int'(col) < bs2d_pkg::MAX_COLS)
						image_copy[int'(row) * bs2d_pkg::MAX_COLS + int'(col)] = sample;
				end else begin
					pending_averages.push_back('{row, col,
						window_average(int'(row), int'(col))});
				end
			end
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (pending_averages.size() == 0) begin
					mismatch_count++;
					$display("%0t: result at (%0d,%0d) expected none actual %0d", $time,
						out_row, out_col, smoothed);
				end else begin
					oldest = pending_averages.pop_front();
					if (out_row !== oldest.r)
						report("out_row", oldest.r, out_row);
					if (out_col !== oldest.c)
						report("out_col", oldest.c, out_col);
					if (smoothed !== oldest.avg)
						report("smoothed", oldest.avg, smoothed);
				end
			end
			averages_owed <= pending_averages.size();
		end
	end

endmodule

@@ bench/tb_box_smooth_2d_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_box_smooth_2d_top
// Stimulus and verdict for the box smoothing engine. A short directed run
// covers full-scale samples, truncation toward zero and the image corners,
// then phases with different window and image settings send random loads
// and smooth requests under varying input gaps and output back-pressure.
// Every smooth window is loaded before it is read.
// ---------------------------------------------------------------------------
module tb_box_smooth_2d_top;

	localparam int LIMIT_CYCLES    = 2_000_000;
	localparam int SETTLE_CYCLES   = 4;
	localparam int TAIL_CYCLES     = 300;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 78;
	localparam int DIRECTED_ITEMS  = 24;

	logic                                 clk       = 1'b0;
	logic                                 arst_n    = 1'b0;
	logic                                 cfg_wr_en = 1'b0;
	bs2d_pkg::cfg_idx_t                   cfg_index = bs2d_pkg::CFG_HALF_COLS;
	logic [bs2d_pkg::CFG_W-1:0]           cfg_data  = '0;
	logic                                 in_valid  = 1'b0;
	logic                                 in_stall;
	logic                                 func      = 1'b0;
	logic [bs2d_pkg::ROW_W-1:0]           row       = '0;
	logic [bs2d_pkg::COL_W-1:0]           col       = '0;
	logic signed [bs2d_pkg::SAMPLE_W-1:0] sample    = '0;
	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	logic [bs2d_pkg::ROW_W-1:0]           out_row;
	logic [bs2d_pkg::COL_W-1:0]           out_col;
	logic signed [bs2d_pkg::SAMPLE_W-1:0] smoothed;
	int                                   averages_owed;
	int                                   mismatch_count;

	int cycle_count   = 0;
	int idle_pct      = 0;
	int stall_pct     = 0;
	int items_sent    = 0;
	int eff_half_cols = 1;
	int eff_half_rows = 1;
	int eff_cols      = 256;
	int eff_rows      = 256;
	int hot_row       = 0;
	int hot_col       = 0;
	bit written [0:bs2d_pkg::DEPTH-1];

	box_smooth_2d_top uut (.*);

	box_smooth_2d_checker avg_check (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("tb_box_smooth_2d_top failed");
			$finish;
		end
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	function automatic int clip_to(input int v, input int lo, input int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic signed [bs2d_pkg::SAMPLE_W-1:0] random_sample();
		case ($urandom_range(7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return bs2d_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [bs2d_pkg::DIM_W-1:0] random_dim();
		if ($urandom_range(9) < 7)
			return bs2d_pkg::DIM_W'($urandom_range(24, 1));
		return bs2d_pkg::DIM_W'($urandom_range(511, 0));
	endfunction

	// A coordinate in the phase's hot area, widened by the given margin.
	function automatic int pick_near(input int base, input int margin);
		return $urandom_range(clip_to(base + 5 + margin, 0, 255), clip_to(base - margin, 0, 255));
	endfunction

	// Entries inside the image and under the window that were never loaded.
	function automatic int missing_in_window(input int ri, input int ci);
		int rr, cc, n;
		n = 0;
		for (rr = clip_to(ri - eff_half_rows, 0, 255); rr < ri + eff_half_rows && rr < eff_rows;
			rr++)
			for (cc = clip_to(ci - eff_half_cols, 0, 255);
				cc < ci + eff_half_cols && cc < eff_cols; cc++)
				if (!written[rr * bs2d_pkg::MAX_COLS + cc])
					n++;
		return n;
	endfunction

	task automatic send_item(input bs2d_pkg::func_t f, input int r, input int c,
		input logic signed [bs2d_pkg::SAMPLE_W-1:0] s);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		row <= bs2d_pkg::ROW_W'(r);
		col <= bs2d_pkg::COL_W'(c);
		sample <= s;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		if (f == bs2d_pkg::FUNC_LOAD)
			written[r * bs2d_pkg::MAX_COLS + c] = 1'b1;
		items_sent++;
	endtask

	// Loads whatever the window still lacks, then asks for the average.
	task automatic smooth_at(input int ri, input int ci);
		int rr, cc;
		for (rr = clip_to(ri - eff_half_rows, 0, 255); rr < ri + eff_half_rows && rr < eff_rows;
			rr++)
			for (cc = clip_to(ci - eff_half_cols, 0, 255);
				cc < ci + eff_half_cols && cc < eff_cols; cc++)
				if (!written[rr * bs2d_pkg::MAX_COLS + cc])
					send_item(bs2d_pkg::FUNC_LOAD, rr, cc, random_sample());
		send_item(bs2d_pkg::FUNC_SMOOTH, ri, ci, bs2d_pkg::SAMPLE_W'($urandom));
	endtask

	task automatic random_item();
		int r, c, far_r, far_c;
		if ($urandom_range(99) < 55) begin
			if ($urandom_range(4) == 0) begin
				r = $urandom_range(255);
				c = $urandom_range(255);
			end else begin
				r = pick_near(hot_row, eff_half_rows);
				c = pick_near(hot_col, eff_half_cols);
			end
			send_item(bs2d_pkg::FUNC_LOAD, r, c, random_sample());
		end else begin
			r = pick_near(hot_row, 0);
			c = pick_near(hot_col, 0);
			// Now and then a smooth far from the hot area, when its window is cheap to fill.
			if ($urandom_range(5) == 0) begin
				far_r = $urandom_range(255);
				far_c = $urandom_range(255);
				if (missing_in_window(far_r, far_c) <= 24) begin
					r = far_r;
					c = far_c;
				end
			end
			smooth_at(r, c);
		end
	endtask

	// Holds the input off until every requested average has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (averages_owed != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input bs2d_pkg::cfg_idx_t idx,
		input logic [bs2d_pkg::CFG_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic set_geometry(input logic [bs2d_pkg::HALF_W-1:0] hw,
		input logic [bs2d_pkg::HALF_W-1:0] hh, input logic [bs2d_pkg::DIM_W-1:0] nc,
		input logic [bs2d_pkg::DIM_W-1:0] nr);
		logic [bs2d_pkg::CFG_W-1:0] value;
		// Bits above the four-bit half sizes are don't-care, so they get noise.
		value = bs2d_pkg::CFG_W'($urandom);
		value[bs2d_pkg::HALF_W-1:0] = hw;
		write_reg(bs2d_pkg::CFG_HALF_COLS, value);
		value = bs2d_pkg::CFG_W'($urandom);
		value[bs2d_pkg::HALF_W-1:0] = hh;
		write_reg(bs2d_pkg::CFG_HALF_ROWS, value);
		write_reg(bs2d_pkg::CFG_IMG_COLS, nc);
		write_reg(bs2d_pkg::CFG_IMG_ROWS, nr);
		cfg_wr_en <= 1'b0;
		eff_half_cols = clip_to(int'(hw), 1, bs2d_pkg::MAX_HALF);
		eff_half_rows = clip_to(int'(hh), 1, bs2d_pkg::MAX_HALF);
		eff_cols = clip_to(int'(nc), 1, bs2d_pkg::COLS_LIMIT);
		eff_rows = clip_to(int'(nr), 1, bs2d_pkg::ROWS_LIMIT);
	endtask

	initial begin
		int  p, i, phase_end, phase_mid;
		bit  paused;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry: 2 x 2 window over a 256 x 256 image.
		for (i = 0; i < 4; i++)
			send_item(bs2d_pkg::FUNC_LOAD, i / 2, i % 2, 16'sh7FFF);
		smooth_at(1, 1);
		for (i = 0; i < 4; i++)
			send_item(bs2d_pkg::FUNC_LOAD, i / 2, i % 2, 16'sh8000);
		smooth_at(1, 1);
		// Only one entry of this window lies inside the image.
		smooth_at(0, 0);
		// A small negative sum has to truncate toward zero, not round down.
		send_item(bs2d_pkg::FUNC_LOAD, 0, 0, -16'sd3);
		smooth_at(0, 0);
		send_item(bs2d_pkg::FUNC_LOAD, 254, 254, 16'sh5555);
		send_item(bs2d_pkg::FUNC_LOAD, 254, 255, 16'shAAAA);
		send_item(bs2d_pkg::FUNC_LOAD, 255, 254, 16'shAAAA);
		send_item(bs2d_pkg::FUNC_LOAD, 255, 255, 16'sh5555);
		smooth_at(255, 255);
		smooth_at(0, 255);
		smooth_at(255, 0);

		for (p = 0; p < PHASES; p++) begin
			wait_drained();
			case (p)
				0: set_geometry(4'd8, 4'd8, 9'd256, 9'd256);
				1: set_geometry(4'd0, 4'd0, 9'd0, 9'd0);
				2: set_geometry(4'd15, 4'd9, 9'd511, 9'd300);
				3: set_geometry(4'd1, 4'd8, 9'd1, 9'd256);
				4: set_geometry(4'd8, 4'd1, 9'd256, 9'd1);
				default: set_geometry(bs2d_pkg::HALF_W'($urandom), bs2d_pkg::HALF_W'($urandom),
					random_dim(), random_dim());
			endcase
			case (p % 4)
				0: begin
					idle_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					idle_pct = 79;
					stall_pct <= 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct <= 79;
				end
				default: begin
					idle_pct = 27;
					stall_pct <= 27;
				end
			endcase
			// Work either at the origin or straddling the far edge of the image.
			hot_row = $urandom_range(1) ? clip_to(eff_rows - 3, 0, 255) : 0;
			hot_col = $urandom_range(1) ? clip_to(eff_cols - 3, 0, 255) : 0;
			phase_end = DIRECTED_ITEMS + (p + 1) * ITEMS_PER_PHASE;
			phase_mid = phase_end - ITEMS_PER_PHASE / 2;
			paused = 1'b0;
			while (items_sent < phase_end) begin
				if (!paused && items_sent >= phase_mid) begin
					wait_drained();
					paused = 1'b1;
				end
				random_item();
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && averages_owed == 0)
			$display("tb_box_smooth_2d_top passed");
		else
			$display("tb_box_smooth_2d_top failed");
		$finish;
	end

endmodule
